[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset
`define CHECK_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("check failed");

// Check that ante is followed by cons on the next edge
`define CHECK_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

[rtl/core/cirb_pkg.sv]
package cirb_pkg;

   localparam int unsigned IRQ_LINES         = 32;
   localparam int unsigned BUS_ERROR_BIT_POS = 8;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic [4:0] REG_IRR     = 5'd0;
   localparam logic [4:0] REG_IMR     = 5'd1;
   localparam logic [4:0] REG_IPR     = 5'd2;
   localparam logic [4:0] REG_ICR     = 5'd3;
   localparam logic [4:0] REG_IAR     = 5'd4;
   localparam logic [4:0] REG_RTC     = 5'd11;
   localparam logic [4:0] REG_PCR     = 5'd13;
   localparam logic [4:0] REG_ERRLOG  = 5'd16;
   localparam logic [4:0] REG_AMR     = 5'd17;
   localparam logic [4:0] REG_LAST    = REG_AMR;

   localparam logic [31:0] MSG_ADDR_RESET = 32'hFFFB_0003;
   localparam logic [31:0] POWER_OFF_CODE = 32'h0000_0002;
   localparam logic [31:0] LOW5_MASK      = 32'h0000_001F;
   localparam logic [31:0] BUS_ERR_MASK   = 32'h1 << BUS_ERROR_BIT_POS;

   typedef struct packed {
      logic [1:0]  op;
      logic [4:0]  reg_index;
      logic [31:0] write_data;
      logic [4:0]  irq_line;
      logic        irq_level;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        access_error;
      logic        msg_valid;
      logic [31:0] msg_address;
      logic [4:0]  msg_data;
      logic        power_off;
   } rsp_type;

endpackage

[rtl/core/chipset_interrupt_register_block.sv]
// A word waits in the input register until advance moves it into the result register.
// Throughput: one word per cycle when rsp_stall is low; each stage holds one word.
// The register file updates in the same cycle as the word moves into the result register.
// Reset (synchronous, active high) empties both stages and returns all registers to
// zero, but the message address register, which returns to 0xFFFB0003.
`include "assert_macros.svh"

module chipset_interrupt_register_block (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cirb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cirb_pkg::rsp_type rsp_data
);

   logic              advance;
   logic              stage_valid;
   cirb_pkg::req_type stage_data;
   cirb_pkg::rsp_type result;
   logic              rsp_msg;

   assign rsp_msg = rsp_valid && rsp_data.msg_valid;

   cirb_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .advance     (advance),
      .stage_valid (stage_valid),
      .stage_data  (stage_data)
   );

   cirb_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (stage_valid && advance),
      .item   (stage_data),
      .result (result)
   );

   cirb_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .stage_valid (stage_valid),
      .result      (result),
      .advance     (advance),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `CHECK_NEXT(a_accept_fills_stage, clock, reset, req_valid && !req_stall, stage_valid)
   `CHECK_ALWAYS(a_msg_addr_aligned, clock, reset, !rsp_msg || (rsp_data.msg_address[4:0] == 5'd0))
   `CHECK_ALWAYS(a_msg_not_on_error, clock, reset, !(rsp_msg && rsp_data.access_error))
   `CHECK_NEXT(a_advance_loads_result, clock, reset, stage_valid && advance, rsp_valid)

endmodule

[rtl/core/cirb_in_stage.sv]
module cirb_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cirb_pkg::req_type req_data,
   input  logic              advance,
   output logic              stage_valid,
   output cirb_pkg::req_type stage_data
);

   logic              valid_ff;
   logic              valid_in;
   cirb_pkg::req_type data_ff;
   cirb_pkg::req_type data_in;

   assign req_stall   = valid_ff && !advance;
   assign stage_valid = valid_ff;
   assign stage_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
      if (req_valid && !req_stall) begin
         data_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

[rtl/core/cirb_core.sv]
module cirb_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  cirb_pkg::req_type item,
   output cirb_pkg::rsp_type result
);

   logic [31:0] irr_ff, irr_in;
   logic [31:0] imr_ff, imr_in;
   logic [31:0] ipr_ff, ipr_in;
   logic [31:0] icr_ff, icr_in;
   logic [31:0] iar_ff, iar_in;
   logic [31:0] errlog_ff, errlog_in;
   logic [31:0] amr_ff, amr_in;
   logic [31:0] offset_ff, offset_in;
   logic [31:0] seconds_ff, seconds_in;
   logic [31:0] line_bit;
   logic        line_ok;

   assign line_bit = 32'h1 << item.irq_line;
   assign line_ok  = item.irq_level
                     && ({1'b0, item.irq_line} < 6'(cirb_pkg::IRQ_LINES));

   always_comb begin
      irr_in     = irr_ff;
      imr_in     = imr_ff;
      ipr_in     = ipr_ff;
      icr_in     = icr_ff;
      iar_in     = iar_ff;
      errlog_in  = errlog_ff;
      amr_in     = amr_ff;
      offset_in  = offset_ff;
      seconds_in = seconds_ff;
      result     = '0;
      case (item.op)
         cirb_pkg::OP_READ: begin
            if (item.reg_index > cirb_pkg::REG_LAST) begin
               result.access_error = 1'b1;
            end else begin
               unique case (item.reg_index)
                  cirb_pkg::REG_IRR: result.read_data = irr_ff;
                  cirb_pkg::REG_IMR: result.read_data = imr_ff;
                  cirb_pkg::REG_IPR: begin
                     result.read_data = ipr_ff;
                     ipr_in           = '0;
                  end
                  cirb_pkg::REG_ICR: result.read_data = icr_ff & cirb_pkg::BUS_ERR_MASK;
                  cirb_pkg::REG_IAR: result.read_data = iar_ff;
                  cirb_pkg::REG_RTC: result.read_data = seconds_ff + offset_ff;
                  cirb_pkg::REG_ERRLOG: result.read_data = errlog_ff;
                  cirb_pkg::REG_AMR: result.read_data = amr_ff;
                  default: result.read_data = '0;
               endcase
            end
         end
         cirb_pkg::OP_WRITE: begin
            if (item.reg_index > cirb_pkg::REG_LAST) begin
               result.access_error = 1'b1;
            end else begin
               unique case (item.reg_index)
                  cirb_pkg::REG_IMR: imr_in = item.write_data;
                  cirb_pkg::REG_IPR: ipr_in = '0;
                  cirb_pkg::REG_ICR: icr_in = item.write_data;
                  cirb_pkg::REG_IAR: iar_in = item.write_data;
                  cirb_pkg::REG_RTC: offset_in = item.write_data - seconds_ff;
                  cirb_pkg::REG_PCR: begin
                     result.power_off = (item.write_data == cirb_pkg::POWER_OFF_CODE);
                  end
                  cirb_pkg::REG_ERRLOG: errlog_in = item.write_data;
                  cirb_pkg::REG_AMR: amr_in = item.write_data;
                  default: ;
               endcase
            end
         end
         cirb_pkg::OP_EVENT: begin
            if (line_ok) begin
               ipr_in = ipr_ff | line_bit;
               if ((line_bit & imr_ff) != '0) begin
                  irr_in = irr_ff | line_bit;
                  if ((icr_ff & cirb_pkg::BUS_ERR_MASK) == '0) begin
                     result.msg_valid   = 1'b1;
                     result.msg_address = iar_ff & ~cirb_pkg::LOW5_MASK;
                     result.msg_data    = iar_ff[4:0];
                  end
               end
            end
         end
         default: begin
            seconds_in = seconds_ff + 32'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irr_ff     <= '0;
         imr_ff     <= '0;
         ipr_ff     <= '0;
         icr_ff     <= '0;
         iar_ff     <= cirb_pkg::MSG_ADDR_RESET;
         errlog_ff  <= '0;
         amr_ff     <= '0;
         offset_ff  <= '0;
         seconds_ff <= '0;
      end else if (fire) begin
         irr_ff     <= irr_in;
         imr_ff     <= imr_in;
         ipr_ff     <= ipr_in;
         icr_ff     <= icr_in;
         iar_ff     <= iar_in;
         errlog_ff  <= errlog_in;
         amr_ff     <= amr_in;
         offset_ff  <= offset_in;
         seconds_ff <= seconds_in;
      end
   end

endmodule

[rtl/core/cirb_out_stage.sv]
module cirb_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              stage_valid,
   input  cirb_pkg::rsp_type result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cirb_pkg::rsp_type rsp_data
);

   logic              valid_ff;
   logic              valid_in;
   cirb_pkg::rsp_type data_ff;
   cirb_pkg::rsp_type data_in;

   assign advance   = !valid_ff || !rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = stage_valid;
         if (stage_valid) begin
            data_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

endmodule

[bench/testbench.sv]
module testbench;

   localparam logic [4:0] REG_VERSION = 5'd14;
   localparam logic [4:0] REG_UNKNOWN = cirb_pkg::REG_LAST + 5'd1;
   localparam logic [4:0] REG_TOP     = 5'd31;
   localparam int RANDOM_WORDS = 950;
   localparam int PHASE_WORDS  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 200000;

   typedef struct {
      cirb_pkg::req_type word;
      bit                fixed;
      cirb_pkg::rsp_type fixed_rsp;
   } plan_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   cirb_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   cirb_pkg::rsp_type rsp_data;

   plan_row_type      plan_q[$];
   cirb_pkg::rsp_type rsp_due_q[$];
   int                sent_count = 0;
   int                idle_phase = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;

   logic [31:0] sh_request, sh_mask, sh_pending, sh_control, sh_msg_addr;
   logic [31:0] sh_err_log, sh_arb_mode, sh_rtc_offset, sh_seconds;

   chipset_interrupt_register_block u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic cirb_pkg::rsp_type make_rsp(logic [31:0] rd, logic aerr, logic mv,
                                                  logic [31:0] ma, logic [4:0] md, logic po);
      cirb_pkg::rsp_type r;
      r.read_data    = rd;
      r.access_error = aerr;
      r.msg_valid    = mv;
      r.msg_address  = ma;
      r.msg_data     = md;
      r.power_off    = po;
      return r;
   endfunction

   function automatic void add_row(logic [1:0] op, logic [4:0] idx, logic [31:0] data,
                                   logic [4:0] line, logic lvl, bit fixed,
                                   cirb_pkg::rsp_type rsp);
      plan_row_type row;
      row.word.op         = op;
      row.word.reg_index  = idx;
      row.word.write_data = data;
      row.word.irq_line   = line;
      row.word.irq_level  = lvl;
      row.fixed           = fixed;
      row.fixed_rsp       = rsp;
      plan_q.push_back(row);
   endfunction

   function automatic cirb_pkg::rsp_type predict_register_access(cirb_pkg::req_type w);
      cirb_pkg::rsp_type r;
      logic [31:0]       line_bit;
      r = '0;
      line_bit = 32'h1 << w.irq_line;
      case (w.op)
         cirb_pkg::OP_READ, cirb_pkg::OP_WRITE: begin
            if (w.reg_index > cirb_pkg::REG_LAST) begin
               r.access_error = 1'b1;
            end else if (w.op == cirb_pkg::OP_READ) begin
               case (w.reg_index)
                  cirb_pkg::REG_IRR:    r.read_data = sh_request;
                  cirb_pkg::REG_IMR:    r.read_data = sh_mask;
                  cirb_pkg::REG_IPR: begin
                     r.read_data = sh_pending;
                     sh_pending = '0;
                  end
                  cirb_pkg::REG_ICR:    r.read_data = sh_control & cirb_pkg::BUS_ERR_MASK;
                  cirb_pkg::REG_IAR:    r.read_data = sh_msg_addr;
                  cirb_pkg::REG_RTC:    r.read_data = sh_seconds + sh_rtc_offset;
                  cirb_pkg::REG_ERRLOG: r.read_data = sh_err_log;
                  cirb_pkg::REG_AMR:    r.read_data = sh_arb_mode;
                  default:              r.read_data = '0;
               endcase
            end else begin
               case (w.reg_index)
                  cirb_pkg::REG_IMR:    sh_mask = w.write_data;
                  cirb_pkg::REG_IPR:    sh_pending = '0;
                  cirb_pkg::REG_ICR:    sh_control = w.write_data;
                  cirb_pkg::REG_IAR:    sh_msg_addr = w.write_data;
                  cirb_pkg::REG_RTC:    sh_rtc_offset = w.write_data - sh_seconds;
                  cirb_pkg::REG_PCR:    r.power_off = (w.write_data == cirb_pkg::POWER_OFF_CODE);
                  cirb_pkg::REG_ERRLOG: sh_err_log = w.write_data;
                  cirb_pkg::REG_AMR:    sh_arb_mode = w.write_data;
                  default: ;
               endcase
            end
         end
         cirb_pkg::OP_EVENT: begin
            if (w.irq_level && w.irq_line < cirb_pkg::IRQ_LINES) begin
               sh_pending = sh_pending | line_bit;
               if ((line_bit & sh_mask) != '0) begin
                  sh_request = sh_request | line_bit;
                  if ((sh_control & cirb_pkg::BUS_ERR_MASK) == '0) begin
                     r.msg_valid   = 1'b1;
                     r.msg_address = sh_msg_addr & ~cirb_pkg::LOW5_MASK;
                     r.msg_data    = sh_msg_addr[4:0];
                  end
               end
            end
         end
         default: sh_seconds = sh_seconds + 32'd1;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   task automatic check_rsp(cirb_pkg::rsp_type got, cirb_pkg::rsp_type want);
      if (got.read_data !== want.read_data)
         report_mismatch("read_data", got.read_data, want.read_data);
      if (got.access_error !== want.access_error)
         report_mismatch("access_error", 32'(got.access_error), 32'(want.access_error));
      if (got.msg_valid !== want.msg_valid)
         report_mismatch("msg_valid", 32'(got.msg_valid), 32'(want.msg_valid));
      if (got.msg_address !== want.msg_address)
         report_mismatch("msg_address", got.msg_address, want.msg_address);
      if (got.msg_data !== want.msg_data)
         report_mismatch("msg_data", 32'(got.msg_data), 32'(want.msg_data));
      if (got.power_off !== want.power_off)
         report_mismatch("power_off", 32'(got.power_off), 32'(want.power_off));
   endtask

   // sender: hold a stalled word, advance on acceptance
   always @(posedge clock) begin
      plan_row_type      row;
      cirb_pkg::rsp_type due;
      int                idle_pct;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            row = plan_q.pop_front();
            due = predict_register_access(row.word);
            rsp_due_q.push_back(row.fixed ? row.fixed_rsp : due);
            sent_count++;
            idle_phase <= (sent_count / PHASE_WORDS) % 4;
         end
         idle_pct = (idle_phase == 1) ? 84 : (idle_phase == 3) ? 34 : 0;
         if (req_valid && req_stall) begin
            req_valid <= 1'b1;
         end else if (plan_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= plan_q[0].word;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      int stall_pct;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_due_q.size() == 0)
               report_mismatch("result word with nothing due", rsp_data.read_data, '0);
            else
               check_rsp(rsp_data, rsp_due_q.pop_front());
         end
         stall_pct = (idle_phase == 2) ? 84 : (idle_phase == 3) ? 34 : 0;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      cirb_pkg::req_type w;
      int                pick;
      cirb_pkg::rsp_type none;
      none = '0;

      sh_request    = '0;
      sh_mask       = '0;
      sh_pending    = '0;
      sh_control    = '0;
      sh_msg_addr   = cirb_pkg::MSG_ADDR_RESET;
      sh_err_log    = '0;
      sh_arb_mode   = '0;
      sh_rtc_offset = '0;
      sh_seconds    = '0;

      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_IRR, '0, 5'd0, 1'b0, 1'b1, none);
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_IAR, '0, 5'd0, 1'b0, 1'b1,
              make_rsp(cirb_pkg::MSG_ADDR_RESET, 1'b0, 1'b0, '0, '0, 1'b0));
      add_row(cirb_pkg::OP_READ,  REG_TOP, '1, 5'd31, 1'b1, 1'b1,
              make_rsp('0, 1'b1, 1'b0, '0, '0, 1'b0));
      add_row(cirb_pkg::OP_WRITE, REG_UNKNOWN, '1, 5'd0, 1'b0, 1'b1,
              make_rsp('0, 1'b1, 1'b0, '0, '0, 1'b0));
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_PCR, cirb_pkg::POWER_OFF_CODE, 5'd0, 1'b0, 1'b1,
              make_rsp('0, 1'b0, 1'b0, '0, '0, 1'b1));
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_PCR, '1, 5'd0, 1'b0, 1'b1, none);
      add_row(cirb_pkg::OP_READ,  REG_VERSION, '0, 5'd0, 1'b0, 1'b1, none);
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_IMR, '1, 5'd0, 1'b0, 1'b1, none);
      add_row(cirb_pkg::OP_EVENT, cirb_pkg::REG_IRR, '0, 5'd0, 1'b1, 1'b1,
              make_rsp('0, 1'b0, 1'b1, 32'hFFFB_0000, 5'd3, 1'b0));
      add_row(cirb_pkg::OP_EVENT, cirb_pkg::REG_IRR, '0, 5'd31, 1'b0, 1'b1, none);
      add_row(cirb_pkg::OP_EVENT, cirb_pkg::REG_IRR, '0, 5'd31, 1'b1, 1'b1,
              make_rsp('0, 1'b0, 1'b1, 32'hFFFB_0000, 5'd3, 1'b0));
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_IPR, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_IPR, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_ICR, '1, 5'd0, 1'b0, 1'b1, none);
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_ICR, '0, 5'd0, 1'b0, 1'b1,
              make_rsp(cirb_pkg::BUS_ERR_MASK, 1'b0, 1'b0, '0, '0, 1'b0));
      add_row(cirb_pkg::OP_EVENT, cirb_pkg::REG_IRR, '0, 5'd5, 1'b1, 1'b0, none);
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_IRR, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_ICR, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_IAR, '1, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_EVENT, cirb_pkg::REG_IRR, '0, 5'd7, 1'b1, 1'b1,
              make_rsp('0, 1'b0, 1'b1, 32'hFFFF_FFE0, 5'd31, 1'b0));
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_RTC, '1, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_TICK,  cirb_pkg::REG_IRR, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_RTC, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_AMR, 32'h5A5A_5A5A, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_READ,  cirb_pkg::REG_AMR, '0, 5'd0, 1'b0, 1'b0, none);
      add_row(cirb_pkg::OP_WRITE, cirb_pkg::REG_IPR, '0, 5'd0, 1'b0, 1'b0, none);

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         pick = $urandom_range(99);
         w.op = (pick < 30) ? cirb_pkg::OP_READ : (pick < 60) ? cirb_pkg::OP_WRITE :
                (pick < 90) ? cirb_pkg::OP_EVENT : cirb_pkg::OP_TICK;
         if ($urandom_range(99) < 88)
            w.reg_index = 5'($urandom_range(32'(cirb_pkg::REG_LAST)));
         else
            w.reg_index = 5'($urandom_range(32'(REG_TOP), 32'(REG_UNKNOWN)));
         w.write_data = $urandom;
         w.irq_line   = 5'($urandom_range(cirb_pkg::IRQ_LINES - 1));
         w.irq_level  = ($urandom_range(99) < 85);
         if (w.op == cirb_pkg::OP_WRITE) begin
            case (w.reg_index)
               cirb_pkg::REG_ICR: begin
                  if ($urandom_range(99) < 70)
                     w.write_data = w.write_data & ~cirb_pkg::BUS_ERR_MASK;
               end
               cirb_pkg::REG_PCR: begin
                  if ($urandom_range(1) == 1) w.write_data = cirb_pkg::POWER_OFF_CODE;
               end
               cirb_pkg::REG_IMR: if ($urandom_range(3) == 0) w.write_data = '1;
               default: ;
            endcase
         end
         add_row(w.op, w.reg_index, w.write_data, w.irq_line, w.irq_level, 1'b0, none);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (plan_q.size() != 0) @(posedge clock);
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && rsp_due_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
